>>> rtl/sem_pkg.sv
// shared types, constants and the square root step of the edge magnitude unit
package sem_pkg;

  // default and reset values
  localparam int unsigned MAX_WIDTH      = 2048;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam logic [11:0] WIDTH_RESET    = 12'd640;
  localparam logic [15:0] HEIGHT_RESET   = 16'd480;

  // configuration port
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // gradient pair of one interior pixel, front to back
  typedef struct packed {
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic               frame_end;
  } grad_t;

  // square root pipeline stage contents
  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] root;
    logic        clip;
    logic        frame_end;
  } root_t;

  // one step of the digit-by-digit integer square root
  function automatic root_t sqrt_step(root_t s, logic [14:0] step_bit);
    root_t       r;
    logic [16:0] trial;
    r = s;
    trial = {1'b0, s.root} + {2'b00, step_bit};
    if ({1'b0, s.rem} >= trial) begin
      r.rem  = s.rem - trial[15:0];
      r.root = (s.root >> 1) + {1'b0, step_bit};
    end else begin
      r.root = s.root >> 1;
    end
    return r;
  endfunction

endpackage

>>> rtl/sem_front.sv
// front part: frame counters, line buffers, 3x3 window and gradient kernels
module sem_front #(
  parameter int unsigned MaxWidth = sem_pkg::MAX_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [7:0]                     red_value_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output sem_pkg::grad_t                 q_item_o
);
  import sem_pkg::*;

  localparam int unsigned ColW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;

  logic [11:0]       width_q;
  logic [15:0]       height_q;
  logic [ColW-1:0]   col_q, col_d, w_last;
  logic [15:0]       row_q, row_d, h_last;
  logic              accept;
  logic              cfg_hit;

  logic              s1_vld_q, s1_vld_d;
  logic [7:0]        s1_pix_q;
  logic [ColW-1:0]   s1_col_q;
  logic              s1_int_q;
  logic              s1_fend_q;
  logic              s1_adv;

  logic [7:0]        mid_mem [MaxWidth];
  logic [7:0]        top_mem [MaxWidth];
  logic [7:0]        mid_rd_q, top_rd_q;
  logic [7:0]        win_q [6];

  logic signed [10:0] tl, tc, tr, ml, mr, bl, bc, br;

  // clamped frame geometry
  always_comb begin
    if (32'(width_q) < 32'd3) begin
      w_last = ColW'(2);
    end else if (32'(width_q) > MaxWidth) begin
      w_last = ColW'(MaxWidth - 1);
    end else begin
      w_last = ColW'(32'(width_q) - 32'd1);
    end
    h_last = (height_q < 16'd3) ? 16'd2 : height_q - 16'd1;
  end

  assign cfg_hit = cfg_we_i && (cfg_idx_i == REG_IMAGE_WIDTH || cfg_idx_i == REG_IMAGE_HEIGHT);
  assign accept  = push_i && !full_o;

  // raster position of the next item
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == w_last) begin
        col_d = '0;
        row_d = (row_q == h_last) ? 16'd0 : row_q + 16'd1;
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  // configuration registers and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i[11:0];
      end
      if (cfg_we_i && cfg_idx_i == REG_IMAGE_HEIGHT) begin
        height_q <= cfg_data_i;
      end
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // window stage handshake
  assign s1_adv   = s1_vld_q && (!s1_int_q || !q_full_i);
  assign full_o   = s1_vld_q && !s1_adv;
  assign q_push_o = s1_vld_q && s1_int_q && !q_full_i;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  // item fields held for the window stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= red_value_i;
      s1_col_q  <= col_q;
      s1_int_q  <= (col_q >= ColW'(2)) && (row_q >= 16'd2);
      s1_fend_q <= (col_q == w_last) && (row_q == h_last);
    end
  end

  // line buffers: read on accept, written back when the item leaves the window stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mid_rd_q <= mid_mem[col_q];
      top_rd_q <= top_mem[col_q];
    end
    if (s1_adv) begin
      mid_mem[s1_col_q] <= s1_pix_q;
      top_mem[s1_col_q] <= mid_rd_q;
    end
  end

  // window columns shift by one per item
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_rd_q;
      win_q[4] <= mid_rd_q;
      win_q[5] <= s1_pix_q;
    end
  end

  // gradient kernels on the 3x3 window
  always_comb begin
    tl = signed'({3'b000, win_q[0]});
    ml = signed'({3'b000, win_q[1]});
    bl = signed'({3'b000, win_q[2]});
    tc = signed'({3'b000, win_q[3]});
    bc = signed'({3'b000, win_q[5]});
    tr = signed'({3'b000, top_rd_q});
    mr = signed'({3'b000, mid_rd_q});
    br = signed'({3'b000, s1_pix_q});
    q_item_o.gx        = (tr - tl) + ((mr - ml) <<< 1) + (br - bl);
    q_item_o.gy        = (bl - tl) + ((bc - tc) <<< 1) + (br - tr);
    q_item_o.frame_end = s1_fend_q;
  end

  // checks
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_vld_q)
    else $error("accepted item did not reach the window stage");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (col_q == '0) && (row_q == 16'd0))
    else $error("register write did not restart the frame");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_hit && !$past(cfg_hit) |-> col_q <= w_last)
    else $error("column counter beyond the row width");

endmodule

>>> rtl/sem_queue.sv
// short queue of gradient pairs between front and back
module sem_queue #(
  parameter int unsigned Depth = sem_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  sem_pkg::grad_t item_i,
  output logic           valid_o,
  input  logic           pop_i,
  output sem_pkg::grad_t item_o
);
  import sem_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  grad_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count beyond its depth");

endmodule

>>> rtl/sem_back.sv
// back part: squares, sum, saturation and pipelined square root
module sem_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  sem_pkg::grad_t q_item_i,
  output logic           q_pop_o,
  output logic           empty_o,
  input  logic           res_pop_i,
  output logic [7:0]     magnitude_o,
  output logic           clipped_o,
  output logic           frame_end_o
);
  import sem_pkg::*;

  localparam int unsigned RootStages = 4;
  localparam int unsigned Last       = RootStages + 1;

  logic               vld_q [Last+1];
  logic               adv;
  logic signed [21:0] px, py;
  logic [19:0]        sqx_q, sqy_q;
  logic               fend0_q;
  logic [20:0]        sum;
  root_t              st_q [RootStages+1];
  root_t              st_d [RootStages+1];

  // whole pipeline moves while the output slot is free or taken
  assign adv     = !vld_q[Last] || res_pop_i;
  assign q_pop_o = adv && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= Last; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= q_valid_i;
      for (int i = 1; i <= Last; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // squared gradients
  assign px = q_item_i.gx * q_item_i.gx;
  assign py = q_item_i.gy * q_item_i.gy;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q   <= px[19:0];
      sqy_q   <= py[19:0];
      fend0_q <= q_item_i.frame_end;
    end
  end

  // sum and saturation check
  assign sum = {1'b0, sqx_q} + {1'b0, sqy_q};

  assign st_d[0] = '{rem: sum[15:0], root: 16'd0, clip: |sum[20:16], frame_end: fend0_q};

  // two root digits per stage
  for (genvar k = 0; k < RootStages; k++) begin : g_root
    assign st_d[k+1] = sqrt_step(sqrt_step(st_q[k], 15'(1) << (14 - 4 * k)),
                                 15'(1) << (12 - 4 * k));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i <= RootStages; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  // result slot
  assign empty_o     = !vld_q[Last];
  assign magnitude_o = st_q[RootStages].clip ? 8'hFF : st_q[RootStages].root[7:0];
  assign clipped_o   = st_q[RootStages].clip;
  assign frame_end_o = st_q[RootStages].frame_end;

  // checks
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Last] && !res_pop_i |=> vld_q[Last] && $stable(st_q[RootStages]))
    else $error("waiting result changed before it was taken");

  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i && adv)
    else $error("queue popped without an item or room");

endmodule

>>> rtl/sobel_edge_magnitude_unit.sv
// top level of the 3x3 gradient edge magnitude unit
//
// Takes 8-bit red pixels in raster order and, for every pixel off the image border,
// returns floor(sqrt(gx^2 + gy^2)) of the 3x3 gradient kernels, saturated to 255 with
// a clip flag, plus a flag on the last interior pixel of the frame. A result appears
// once the pixel below and right of its center has been taken. One pixel is taken per
// clock, set by the line buffer read and window stage, while the queue has room;
// a result passes through the window stage, the queue, the squaring stage, the sum
// stage and the four-stage square root. Two line
// buffers of MAX_WIDTH bytes each need no clearing pass after reset, since the first
// two rows of every frame fill them before any result reads them. A write to either
// size register restarts the frame; width is clamped to 3..MAX_WIDTH, height to >= 3.
module sobel_edge_magnitude_unit #(
  parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     red_value_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     magnitude_o,
  output logic                           clipped_o,
  output logic                           frame_end_o
);
  import sem_pkg::*;

  logic  q_full, q_push, q_valid, q_pop;
  grad_t q_in, q_out;

  // window and gradient front
  sem_front #(
    .MaxWidth(MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .full_o      (full),
    .red_value_i (red_value_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_in)
  );

  // decoupling queue
  sem_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .item_i  (q_in),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (q_out)
  );

  // magnitude back end
  sem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .empty_o     (empty),
    .res_pop_i   (pop),
    .magnitude_o (magnitude_o),
    .clipped_o   (clipped_o),
    .frame_end_o (frame_end_o)
  );

endmodule
